// File: rtl/core/igpf_pkg.sv
`default_nettype none

package igpf_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_POP  = 2'd2,
    OP_READ = 2'd3
  } op_e;

  // function codes that mark a register read request
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_READ_INPUT   = 8'h04;

  // idle gap register after reset
  localparam logic [6:0] IDLE_TICKS_RESET = 7'd16;

  // slot ring geometry, fixed by the item field widths
  localparam int SLOT_COUNT   = 4;
  localparam int PACKET_BYTES = 256;
  localparam int STORE_AW     = $clog2(SLOT_COUNT * PACKET_BYTES);

  // result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // descriptor handed from front to back, one per accepted item
  typedef struct packed {
    logic       valid;
    op_e        op;
    logic       frame_closed;
    logic       packet_ready;
    logic [1:0] slot;
    logic [8:0] packet_length;
    logic       read_ok;
  } desc_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [1:0] pad;
    logic [7:0] read_data;
    logic       is_register_read;
    logic [8:0] packet_length;
    logic [1:0] slot;
    logic       packet_ready;
    logic       frame_closed;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/idle_gap_packet_framer_fifo_core.sv
`default_nettype none

// Serial frame receiver with a ring of SLOT_COUNT packet slots of PACKET_BYTES
// bytes each. Every input item is one of: a received byte, a timer tick, a pop
// of the oldest closed packet, or a read of a stored byte; each gives exactly
// one result item. A frame closes on the idle_ticks-th tick after its last
// byte (on the first tick if idle_ticks is zero). An item is taken every clock
// cycle while tready is high; its descriptor and the memory read data are
// registered, then the result is finished into a four-entry result queue. The
// packet memory is written or read at most once per item, which sets the
// one-item-per-cycle figure; tready drops only when the result queue has no
// room left once the item still in the front is counted. There is no full
// check on the slot ring: a head that laps the tail loses the stored packets.
module idle_gap_packet_framer_fifo_core
  import igpf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // idle gap register
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // data_byte[7:0], read_slot[9:8], read_index[17:10]
  input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // frame_closed[0], packet_ready[1], slot[3:2],
                                           // packet_length[12:4], is_register_read[13],
                                           // read_data[21:14]
);

  logic                accept;
  logic                credit;
  logic                ram_we, ram_re;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;
  desc_t               desc;

  assign s_axis_tready = credit;
  assign accept        = s_axis_tvalid && credit;

  // front: accept, classify, framing state
  igpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .op_i        (op_e'(s_axis_tuser)),
    .data_byte_i (s_axis_tdata[7:0]),
    .read_slot_i (s_axis_tdata[9:8]),
    .read_index_i(s_axis_tdata[17:10]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .desc_o      (desc)
  );

  // packet store
  igpf_ram #(
    .WIDTH(8),
    .DEPTH(SLOT_COUNT * PACKET_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // back: finish results and queue them for the output
  igpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc),
    .rdata_i      (ram_rdata),
    .credit_o     (credit),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // every accepted item leaves a descriptor in the next cycle
  a_desc_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> desc.valid)
    else $error("accepted item left no descriptor");

  // one memory access per item
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("packet store written and read in one cycle");

  // a byte read or pop result always has a memory read behind it
  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (desc.valid && (desc.read_ok || desc.packet_ready)) |-> $past(ram_re))
    else $error("result uses memory data that was never read");
`endif

endmodule

`default_nettype wire

// File: rtl/core/igpf_ram.sv
`default_nettype none

module igpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/igpf_front.sv
`default_nettype none

module igpf_front
  import igpf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [6:0]          cfg_wdata_i,
  input  wire logic                accept_i,
  input  wire op_e                 op_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic [1:0]          read_slot_i,
  input  wire logic [7:0]          read_index_i,
  output logic                     ram_we_o,
  output logic [STORE_AW-1:0]      ram_waddr_o,
  output logic [7:0]               ram_wdata_o,
  output logic                     ram_re_o,
  output logic [STORE_AW-1:0]      ram_raddr_o,
  output desc_t                    desc_o
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int WCW = $clog2(PACKET_BYTES + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  logic [6:0]     idle_ticks_q;
  logic [WCW-1:0] wcount_q, wcount_d, wcount_eff;
  logic [SW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [6:0]     idle_cnt_q, idle_cnt_d;
  logic           armed_q, armed_d;
  logic [WCW-1:0] slot_len_q [SLOT_COUNT];
  logic           len_we;
  desc_t          desc_q, desc_d;
  logic           read_ok;

  // idle gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_ticks_q <= IDLE_TICKS_RESET;
    end else if (cfg_we_i) begin
      idle_ticks_q <= cfg_wdata_i;
    end
  end

  // byte position wraps back to the slot start once the slot is full
  assign wcount_eff = (int'(wcount_q) >= PACKET_BYTES) ? '0 : wcount_q;
  assign read_ok    = (int'(read_slot_i) < SLOT_COUNT) && (int'(read_index_i) < PACKET_BYTES);

  // classify the item, update framing state and issue the memory access
  always_comb begin
    wcount_d    = wcount_q;
    head_d      = head_q;
    tail_d      = tail_q;
    idle_cnt_d  = idle_cnt_q;
    armed_d     = armed_q;
    len_we      = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_waddr_o = STORE_AW'(int'(head_q) * PACKET_BYTES + int'(wcount_eff));
    ram_wdata_o = data_byte_i;
    ram_raddr_o = STORE_AW'(int'(tail_q) * PACKET_BYTES + 1);
    desc_d       = '0;
    desc_d.valid = accept_i;
    desc_d.op    = op_i;
    if (accept_i) begin
      unique case (op_i)
        OP_BYTE: begin
          ram_we_o   = 1'b1;
          wcount_d   = wcount_eff + WCW'(1);
          idle_cnt_d = idle_ticks_q;
          armed_d    = 1'b1;
        end
        OP_TICK: begin
          if (armed_q) begin
            if (idle_cnt_q <= 7'd1) begin
              len_we              = 1'b1;
              head_d              = (head_q == LAST_SLOT) ? '0 : head_q + SW'(1);
              wcount_d            = '0;
              idle_cnt_d          = '0;
              armed_d             = 1'b0;
              desc_d.frame_closed = 1'b1;
            end else begin
              idle_cnt_d = idle_cnt_q - 7'd1;
            end
          end
        end
        OP_POP: begin
          if (head_q != tail_q) begin
            ram_re_o             = 1'b1;
            desc_d.packet_ready  = 1'b1;
            desc_d.slot          = 2'(tail_q);
            desc_d.packet_length = 9'(slot_len_q[tail_q]);
            tail_d               = (tail_q == LAST_SLOT) ? '0 : tail_q + SW'(1);
          end
        end
        OP_READ: begin
          ram_re_o       = read_ok;
          ram_raddr_o    = STORE_AW'(int'(read_slot_i) * PACKET_BYTES + int'(read_index_i));
          desc_d.read_ok = read_ok;
        end
        default: ;
      endcase
    end
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q   <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      idle_cnt_q <= '0;
      armed_q    <= 1'b0;
      desc_q     <= '0;
    end else begin
      wcount_q   <= wcount_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      idle_cnt_q <= idle_cnt_d;
      armed_q    <= armed_d;
      desc_q     <= desc_d;
    end
  end

  // recorded frame lengths
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      slot_len_q[head_q] <= wcount_q;
    end
  end

  assign desc_o = desc_q;

endmodule

`default_nettype wire

// File: rtl/core/igpf_back.sv
`default_nettype none

module igpf_back
  import igpf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire desc_t       desc_i,
  input  wire logic [7:0]  rdata_i,
  output logic             credit_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata
);

  result_t        res;
  result_t        queue_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q;
  logic           push, pop;

  // finish the result with the memory read data
  always_comb begin
    res                  = '0;
    res.frame_closed     = desc_i.frame_closed;
    res.packet_ready     = desc_i.packet_ready;
    res.slot             = desc_i.slot;
    res.packet_length    = desc_i.packet_length;
    res.is_register_read = desc_i.packet_ready &&
                           ((rdata_i == FC_READ_HOLDING) || (rdata_i == FC_READ_INPUT));
    res.read_data        = (desc_i.op == OP_READ && desc_i.read_ok) ? rdata_i : 8'h00;
  end

  assign push = desc_i.valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  // room for one more item counting the one in flight
  assign credit_o = (count_q + QCW'(desc_i.valid)) < QCW'(QDEPTH);

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= res;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      count_q <= count_q + QCW'(push) - QCW'(pop);
    end
  end

  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = 24'(queue_q[rd_ptr_q]);

endmodule

`default_nettype wire

// File: verif/tb_idle_gap_packet_framer_fifo_core.sv
module tb_idle_gap_packet_framer_fifo_core;
  timeunit 1ns;
  timeprecision 1ps;

  import igpf_pkg::*;

  localparam int SLOTS    = SLOT_COUNT;
  localparam int BYTES    = PACKET_BYTES;
  localparam int WATCHDOG = 2000;

  // one input item as queued for the driver
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [1:0] rslot;
    logic [7:0] ridx;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // data_byte[7:0], read_slot[9:8], read_index[17:10]
  logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // frame_closed[0], packet_ready[1], slot[3:2],
                                    // packet_length[12:4], is_register_read[13],
                                    // read_data[21:14]

  idle_gap_packet_framer_fifo_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // framer state, copy 0 tracks the planned stream, copy 1 the accepted stream
  logic [7:0] frame_mem [2][SLOTS*BYTES];
  int         fill_cnt  [2][SLOTS];
  int         len_tab   [2][SLOTS];
  int         wr_cnt    [2];
  int         head_s    [2];
  int         tail_s    [2];
  int         idle_left [2];
  bit         armed     [2];
  int         gap_cfg   [2] = '{IDLE_TICKS_RESET, IDLE_TICKS_RESET};

  rx_item_t   stim_q[$];
  result_t    expected_q[$];

  int planned_items, results_seen, frames_closed, packets_popped, errors;
  int quiet_cycles, in_wait, out_wait;
  bit calm_in, calm_out;

  // advance one copy of the framer by one item and give its result
  function automatic result_t framer_step(int c, op_e op, logic [7:0] data,
                                          logic [1:0] rslot, logic [7:0] ridx);
    result_t    r;
    logic [7:0] fc;
    r = '0;
    case (op)
      OP_BYTE: begin
        // a full buffer wraps onto its own start
        if (wr_cnt[c] >= BYTES) wr_cnt[c] = 0;
        frame_mem[c][head_s[c]*BYTES + wr_cnt[c]] = data;
        wr_cnt[c]++;
        if (wr_cnt[c] > fill_cnt[c][head_s[c]]) fill_cnt[c][head_s[c]] = wr_cnt[c];
        idle_left[c] = gap_cfg[c];
        armed[c] = 1'b1;
      end
      OP_TICK: begin
        if (armed[c]) begin
          if (idle_left[c] <= 1) begin
            len_tab[c][head_s[c]] = wr_cnt[c];
            head_s[c] = (head_s[c] + 1) % SLOTS;
            wr_cnt[c] = 0;
            idle_left[c] = 0;
            armed[c] = 1'b0;
            r.frame_closed = 1'b1;
          end else begin
            idle_left[c]--;
          end
        end
      end
      OP_POP: begin
        // no full check: a lapped ring looks empty
        if (head_s[c] != tail_s[c]) begin
          fc = frame_mem[c][tail_s[c]*BYTES + 1];
          r.packet_ready = 1'b1;
          r.slot = 2'(tail_s[c]);
          r.packet_length = 9'(len_tab[c][tail_s[c]]);
          r.is_register_read = (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
          tail_s[c] = (tail_s[c] + 1) % SLOTS;
        end
      end
      OP_READ: begin
        if (rslot < SLOTS && ridx < BYTES) r.read_data = frame_mem[c][rslot*BYTES + ridx];
      end
    endcase
    return r;
  endfunction

  // queue one item, steering away from reads of bytes never written
  task automatic plan_item(op_e op, logic [7:0] data, logic [1:0] rslot, logic [7:0] ridx);
    rx_item_t it;
    int       k;
    bit       found;
    if (op == OP_POP && head_s[0] != tail_s[0] && fill_cnt[0][tail_s[0]] < 2) op = OP_TICK;
    if (op == OP_READ && ridx >= fill_cnt[0][rslot]) begin
      found = 1'b0;
      for (k = 0; k < SLOTS; k++) begin
        if (!found && fill_cnt[0][(rslot + k) % SLOTS] > 0) begin
          rslot = 2'((rslot + k) % SLOTS);
          ridx = 8'($urandom_range(0, fill_cnt[0][rslot] - 1));
          found = 1'b1;
        end
      end
      if (!found) op = OP_TICK;
    end
    void'(framer_step(0, op, data, rslot, ridx));
    it.op = op;
    it.data = data;
    it.rslot = rslot;
    it.ridx = ridx;
    stim_q.push_back(it);
    planned_items++;
  endtask

  // a frame of len bytes followed by the ticks that close it, or sometimes fewer
  task automatic send_frame(int len, bit may_break);
    logic [7:0] data;
    int         i, n;
    for (i = 0; i < len; i++) begin
      data = 8'($urandom);
      if (i == 1 && $urandom_range(0, 1)) data = $urandom_range(0, 1) ? FC_READ_HOLDING
                                                                    : FC_READ_INPUT;
      plan_item(OP_BYTE, data, 2'($urandom), 8'($urandom));
    end
    n = (idle_left[0] == 0) ? 1 : idle_left[0];
    if (may_break && $urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
    else n += $urandom_range(0, 2);
    repeat (n) plan_item(OP_TICK, 8'($urandom), 2'($urandom), 8'($urandom));
  endtask

  // wait until every queued item is through and every result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
  endtask

  // idle gap register write while the block is quiet
  task automatic set_gap(int v);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 7'(v);
    gap_cfg[0] = v;
    gap_cfg[1] = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed frames with pops, reads, stray ticks and noise mixed in
  task automatic random_phase(int v, int budget, int first_len);
    int stop, r;
    set_gap(v);
    stop = planned_items + budget;
    if (first_len > 0) begin
      send_frame(first_len, 1'b0);
      // top of a buffer that overflowed
      if (first_len > BYTES) plan_item(OP_READ, 8'($urandom), 2'(head_s[0] + SLOTS - 1),
                                       8'(BYTES - 1));
    end
    while (planned_items < stop) begin
      r = $urandom_range(0, 9);
      if (r < 5) send_frame($urandom_range(1, 10), 1'b1);
      else if (r < 7) repeat ($urandom_range(1, 2))
        plan_item(OP_POP, 8'($urandom), 2'($urandom), 8'($urandom));
      else if (r == 7) repeat ($urandom_range(1, 3))
        plan_item(OP_READ, 8'($urandom), 2'($urandom), 8'($urandom));
      else if (r == 8)
        plan_item(op_e'($urandom_range(0, 3)), 8'($urandom), 2'($urandom), 8'($urandom));
      else repeat ($urandom_range(1, 4))
        plan_item(OP_TICK, 8'($urandom), 2'($urandom), 8'($urandom));
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // driver: presents queued items, predicts on each accepted item
  always @(posedge clk_i or negedge rst_ni) begin : drv_blk
    rx_item_t it;
    bit       fire;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      in_wait = 0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        expected_q.push_back(framer_step(1, op_e'(s_axis_tuser), s_axis_tdata[7:0],
                                         s_axis_tdata[9:8], s_axis_tdata[17:10]));
        if ($urandom_range(0, 31) == 0) calm_in = !calm_in;
        in_wait = calm_in ? 0 : $urandom_range(0, 7);
      end
      if (fire || !s_axis_tvalid) begin
        if (in_wait != 0) begin
          in_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          it = stim_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, it.ridx, it.rslot, it.data};
          s_axis_tuser <= it.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random result stalls, compares each result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : mon_blk
    result_t got, want;
    bit      fire;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_wait = 0;
    end else begin
      fire = m_axis_tvalid && m_axis_tready;
      if (fire) begin
        got = result_t'(m_axis_tdata);
        results_seen++;
        if (got.frame_closed) frames_closed++;
        if (got.packet_ready) packets_popped++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result %h with no item pending", $time, m_axis_tdata);
        end else begin
          want = expected_q.pop_front();
          check_field("frame_closed", int'(want.frame_closed), int'(got.frame_closed));
          check_field("packet_ready", int'(want.packet_ready), int'(got.packet_ready));
          check_field("slot", int'(want.slot), int'(got.slot));
          check_field("packet_length", int'(want.packet_length), int'(got.packet_length));
          check_field("is_register_read", int'(want.is_register_read),
                      int'(got.is_register_read));
          check_field("read_data", int'(want.read_data), int'(got.read_data));
        end
        if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
        out_wait = calm_out ? 0 : $urandom_range(0, 7);
      end
      if (fire || !m_axis_tready) begin
        if (out_wait != 0) begin
          out_wait--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // reset, directed items at the reset gap, then random phases over several gaps
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    plan_item(OP_POP, 8'hFF, 2'd3, 8'hFF);                // pop on empty ring
    plan_item(OP_TICK, 8'h00, 2'd0, 8'h00);               // tick while idle
    plan_item(OP_BYTE, 8'h00, 2'd3, 8'hFF);
    plan_item(OP_BYTE, FC_READ_HOLDING, 2'd0, 8'h00);
    repeat (IDLE_TICKS_RESET) plan_item(OP_TICK, 8'hFF, 2'd3, 8'hFF);
    plan_item(OP_POP, 8'h00, 2'd0, 8'h00);
    plan_item(OP_POP, 8'h00, 2'd0, 8'h00);                // empty again
    plan_item(OP_READ, 8'h00, 2'd0, 8'd1);
    plan_item(OP_READ, 8'hFF, 2'd0, 8'd0);

    random_phase(0, 15, 0);                               // zero gap acts as one
    random_phase(127, 1, $urandom_range(2, 6));
    random_phase(1, 15, 0);
    random_phase(4, 275, $urandom_range(BYTES + 1, BYTES + 8));
    random_phase(2, 15, 0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("%0d items, %0d results checked, %0d frames closed, %0d packets popped",
             planned_items, results_seen, frames_closed, packets_popped);
    $display("idle gaps 16, 0, 127, 1, 4 with a buffer overflow and 2; %0d mismatches",
             errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
